[rtl/core/ptd_pkg.sv]
// Package for the periodic task dispatcher core.
// Holds the field widths, register indexes, request codes and controller state type.
// No dependencies.
package ptd_pkg;

    localparam int TICK_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int MASK_W     = 4;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD0 = 3'd2;

    localparam logic REQ_RUN    = 1'b0;
    localparam logic REQ_RESYNC = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SYNC,
        S_READ,
        S_CALC
    } t_state;

endpackage

[rtl/core/ptd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/periodic_task_dispatcher_core.sv]
// Periodic task dispatcher: top level with controller and config registers.
// Depends on ptd_pkg and ptd_ram (last-fire times).
// Resync: S_SYNC writes each slot's last-fire time in turn. Run: S_READ (RAM read) then S_CALC
// (update) per slot for min(active_count, NUM_TASKS) slots; busy, no new item, until the strobe.
// The receiver cannot stall; each result shows for one cycle.
// Reset: control/config regs and all last-fire times read as zero at once, no clearing pass.
module periodic_task_dispatcher_core
    import ptd_pkg::*;
#(
    parameter int NUM_TASKS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_req_type,
    input  logic [TICK_W-1:0]     i_now_tick,
    output logic                  o_fire_valid,
    output logic [MASK_W-1:0]     o_fire_mask,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam logic [COUNT_W-1:0] NT = COUNT_W'(NUM_TASKS);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_slot, n_slot;
    logic [TICK_W-1:0]     r_now;
    logic [MASK_W-1:0]     r_mask, n_mask;
    logic                  r_out_valid, n_out_valid;
    logic [MASK_W-1:0]     r_out_mask, n_out_mask;
    logic [MASK_W-1:0]     r_enable;
    logic [COUNT_W-1:0]    r_active;
    logic [PERIOD_W-1:0]   r_period [NUM_TASKS];
    logic [NUM_TASKS-1:0]  r_valid_bits;

    logic                  accept;
    logic [COUNT_W-1:0]    slots;
    logic                  run_last;
    logic                  sync_last;
    logic                  ram_we;
    logic [TICK_W-1:0]     ram_wdata;
    logic [TICK_W-1:0]     ram_rdata;
    logic [TICK_W-1:0]     last_time;
    logic [TICK_W-1:0]     elapsed;
    logic [TICK_W-1:0]     period_ext;
    logic [PERIOD_W-1:0]   period;
    logic                  due;
    logic                  late;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign slots     = (r_active > NT) ? NT : r_active;
    assign run_last  = ((COUNT_W'(r_slot) + COUNT_W'(1)) >= slots);
    assign sync_last = (COUNT_W'(r_slot) == (NT - COUNT_W'(1)));

    assign period     = r_period[r_slot];
    assign period_ext = TICK_W'(period);
    assign last_time  = r_valid_bits[r_slot] ? ram_rdata : '0;
    assign elapsed    = r_now - last_time;
    assign due        = r_enable[r_slot] && (elapsed >= period_ext);
    assign late       = (elapsed >= (period_ext << 1));

    ptd_ram #(
        .WIDTH(TICK_W),
        .DEPTH(NUM_TASKS)
    ) u_time_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_slot),
        .i_wdata(ram_wdata),
        .i_raddr(r_slot),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_RESYNC) begin
                        n_state = S_SYNC;
                    end else if (((r_active > NT) ? NT : r_active) != '0) begin
                        n_state = S_READ;
                    end
                end
            end
            S_SYNC: begin
                if (sync_last) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                n_state = run_last ? S_IDLE : S_READ;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_slot      = r_slot;
        n_mask      = r_mask;
        n_out_valid = 1'b0;
        n_out_mask  = r_out_mask;
        ram_we      = 1'b0;
        ram_wdata   = r_now;
        case (r_state)
            S_IDLE: begin
                n_slot = '0;
                n_mask = '0;
                if (accept && (i_req_type == REQ_RUN) && (slots == '0)) begin
                    n_out_valid = 1'b1;
                    n_out_mask  = '0;
                end
            end
            S_SYNC: begin
                ram_we = 1'b1;
                n_slot = r_slot + AW'(1);
                if (sync_last) begin
                    n_out_valid = 1'b1;
                    n_out_mask  = '0;
                end
            end
            S_READ: begin
                n_slot = r_slot;
            end
            S_CALC: begin
                if (due) begin
                    n_mask = r_mask | (MASK_W'(1) << r_slot);
                    if (period != '0) begin
                        ram_we    = 1'b1;
                        ram_wdata = late ? r_now : (last_time + period_ext);
                    end
                end
                n_slot = r_slot + AW'(1);
                if (run_last) begin
                    n_out_valid = 1'b1;
                    n_out_mask  = due ? (r_mask | (MASK_W'(1) << r_slot)) : r_mask;
                end
            end
            default: begin
                n_slot = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot       <= '0;
            r_mask       <= '0;
            r_out_valid  <= 1'b0;
            r_out_mask   <= '0;
            r_enable     <= '0;
            r_active     <= '0;
            r_valid_bits <= '0;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_period[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
            r_out_mask  <= n_out_mask;
            if (ram_we) begin
                r_valid_bits[r_slot] <= 1'b1;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ENABLE) begin
                    r_enable <= i_cfg_data[MASK_W-1:0];
                end
                if (i_cfg_idx == CFG_ACTIVE) begin
                    r_active <= i_cfg_data[COUNT_W-1:0];
                end
                for (int i = 0; i < NUM_TASKS; i++) begin
                    if (i_cfg_idx == (CFG_PERIOD0 + CFG_IDX_W'(i))) begin
                        r_period[i] <= i_cfg_data[PERIOD_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now <= i_now_tick;
        end
    end

    assign o_fire_valid = r_out_valid;
    assign o_fire_mask  = r_out_mask;

endmodule

[verif/periodic_task_dispatcher_core_tb.sv]
// Self-checking testbench for periodic_task_dispatcher_core: directed table, then random phases
// of resync/run items on mostly rising ticks, with an in-bench scheduler model predicting masks.
// Depends on ptd_pkg and the dispatcher RTL.
`timescale 1ns / 1ps

module periodic_task_dispatcher_core_tb;
    import ptd_pkg::*;

    localparam int          N_SLOTS         = 4;
    localparam int          SLOT_W          = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1;
    localparam int unsigned LATE_MULT       = 2;
    localparam int          N_PLAN          = 40;
    localparam int          N_PHASES        = 12;
    localparam int          ITEMS_PER_PHASE = 127;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE0 = CFG_PERIOD0 + CFG_IDX_W'(N_SLOTS);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE1 = CFG_SPARE0 + 3'd1;

    typedef enum logic {ROW_REG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic                 req;
        logic [CFG_IDX_W-1:0] idx;
        logic [TICK_W-1:0]    val;
        logic                 known;
        logic [MASK_W-1:0]    mask;
    } t_plan_row;

    typedef struct packed {
        logic              known;
        logic [MASK_W-1:0] mask;
    } t_mask_hint;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  i_req_type = REQ_RUN;
    logic [TICK_W-1:0]     i_now_tick = '0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  busy;
    logic                  o_fire_valid;
    logic [MASK_W-1:0]     o_fire_mask;

    logic [TICK_W-1:0]   last_fire_at [N_SLOTS];
    logic [MASK_W-1:0]   enable_bits  = '0;
    logic [COUNT_W-1:0]  active_slots = '0;
    logic [PERIOD_W-1:0] task_period  [N_SLOTS];

    logic [MASK_W-1:0] fire_mask_q [$];
    t_mask_hint        hint_q      [$];
    t_plan_row         plan        [N_PLAN];
    int                mismatch_count = 0;
    int unsigned       cycle_count    = 0;

    periodic_task_dispatcher_core #(
        .NUM_TASKS (N_SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_now_tick   (i_now_tick),
        .o_fire_valid (o_fire_valid),
        .o_fire_mask  (o_fire_mask),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [MASK_W-1:0] next_fire_mask(logic req, logic [TICK_W-1:0] now);
        logic [MASK_W-1:0] fired;
        logic [TICK_W-1:0] elapsed;
        logic [TICK_W-1:0] per;
        int                n;
        fired = '0;
        if (req == REQ_RESYNC) begin
            for (int i = 0; i < N_SLOTS; i++) last_fire_at[i] = now;
            return fired;
        end
        n = (active_slots > N_SLOTS) ? N_SLOTS : int'(active_slots);
        for (int i = 0; i < n; i++) begin
            per = TICK_W'(task_period[i]);
            if (enable_bits[i]) begin
                if (per == '0) begin
                    fired[i] = 1'b1;
                end else begin
                    elapsed = now - last_fire_at[i];
                    if (elapsed >= per) begin
                        if (elapsed >= per * LATE_MULT) last_fire_at[i] = now;
                        else last_fire_at[i] = last_fire_at[i] + per;
                        fired[i] = 1'b1;
                    end
                end
            end
        end
        return fired;
    endfunction

    always @(posedge i_clk) begin
        t_mask_hint        hint;
        logic [MASK_W-1:0] want;
        logic [MASK_W-1:0] got;
        if (!i_rst_n) begin
            enable_bits  = '0;
            active_slots = '0;
            for (int i = 0; i < N_SLOTS; i++) begin
                last_fire_at[i] = '0;
                task_period[i]  = '0;
            end
        end else begin
            if (o_fire_valid) begin
                if (fire_mask_q.size() == 0) begin
                    $error("fire_mask: expected none, got %0h", o_fire_mask);
                    mismatch_count++;
                end else begin
                    want = fire_mask_q.pop_front();
                    if (o_fire_mask !== want) begin
                        $error("fire_mask: expected %0h, got %0h", want, o_fire_mask);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ENABLE) enable_bits = i_cfg_data[MASK_W-1:0];
                else if (i_cfg_idx == CFG_ACTIVE) active_slots = i_cfg_data[COUNT_W-1:0];
                else if (i_cfg_idx >= CFG_PERIOD0 && i_cfg_idx < CFG_SPARE0)
                    task_period[SLOT_W'(i_cfg_idx - CFG_PERIOD0)] = i_cfg_data;
            end
            if (start && !busy) begin
                hint = hint_q.pop_front();
                got  = next_fire_mask(i_req_type, i_now_tick);
                fire_mask_q.push_back(hint.known ? hint.mask : got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic issue_item(logic req, logic [TICK_W-1:0] tick, logic known,
                              logic [MASK_W-1:0] mask);
        start      <= 1'b1;
        i_req_type <= req;
        i_now_tick <= tick;
        i_cfg_we   <= 1'b0;
        hint_q.push_back({known, mask});
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic idle_for(int n);
        repeat (n) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (fire_mask_q.size() != 0 || busy) @(negedge i_clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    initial begin
        logic [PERIOD_W-1:0] per [N_SLOTS];
        logic [TICK_W-1:0]   tick;
        logic [TICK_W-1:0]   step_max;
        logic [PERIOD_W-1:0] max_per;
        logic [CFG_DATA_W-1:0] en_val;
        logic [CFG_DATA_W-1:0] act_val;
        logic                gappy;

        plan = '{
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h0000_0000, 1'b1, 4'h0},
            '{ROW_ITEM, REQ_RESYNC, CFG_ENABLE,  32'hFFFF_FFFF, 1'b1, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_ENABLE,  32'h0000_000F, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_ACTIVE,  32'h0000_0007, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_PERIOD0, 32'h0000_0000, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_PERIOD0 + 3'd1, 32'h0000_0001, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_PERIOD0 + 3'd2, 32'h0000_FFFF, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_PERIOD0 + 3'd3, 32'h0000_0002, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_SPARE0,  32'h0000_FFFF, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_SPARE1,  32'h0000_FFFF, 1'b0, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'hFFFF_FFFF, 1'b1, 4'h1},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h0000_0000, 1'b0, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h0000_0002, 1'b0, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h0000_FFFE, 1'b0, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h0001_FFFD, 1'b0, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h8000_0000, 1'b0, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'hAAAA_AAAA, 1'b0, 4'h0},
            '{ROW_ITEM, REQ_RESYNC, CFG_ENABLE,  32'h5555_5555, 1'b1, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h5555_FFFF, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_ENABLE,  32'h0000_FFF5, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_ACTIVE,  32'h0000_FFFA, 1'b0, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h5556_FFFF, 1'b0, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h5557_0000, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_ACTIVE,  32'h0000_0000, 1'b0, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'hFFFF_FFFF, 1'b1, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_ENABLE,  32'h0000_0000, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_ACTIVE,  32'h0000_0004, 1'b0, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h0000_1234, 1'b1, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_ENABLE,  32'h0000_000F, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_PERIOD0, 32'h0000_FFFF, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_PERIOD0 + 3'd1, 32'h0000_FFFF, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_PERIOD0 + 3'd2, 32'h0000_FFFF, 1'b0, 4'h0},
            '{ROW_REG,  REQ_RUN,    CFG_PERIOD0 + 3'd3, 32'h0000_FFFF, 1'b0, 4'h0},
            '{ROW_ITEM, REQ_RESYNC, CFG_ENABLE,  32'h0000_0000, 1'b1, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h0000_FFFE, 1'b1, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h0000_FFFF, 1'b1, 4'hF},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h0001_FFFD, 1'b1, 4'h0},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h0001_FFFE, 1'b1, 4'hF},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h0003_FFFC, 1'b1, 4'hF},
            '{ROW_ITEM, REQ_RUN,    CFG_ENABLE,  32'h0004_0000, 1'b0, 4'h0}
        };

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_REG) begin
                settle();
                put_reg(plan[r].idx, plan[r].val[CFG_DATA_W-1:0]);
            end else begin
                issue_item(plan[r].req, plan[r].val, plan[r].known, plan[r].mask);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            max_per = '0;
            for (int i = 0; i < N_SLOTS; i++) begin
                if (ph == 0) per[i] = '0;
                else if (ph == 1) per[i] = '1;
                else begin
                    case ($urandom_range(0, 7))
                        0:       per[i] = '0;
                        1:       per[i] = PERIOD_W'($urandom_range(0, 65535));
                        default: per[i] = PERIOD_W'($urandom_range(1, 24));
                    endcase
                end
                if (per[i] > max_per) max_per = per[i];
            end
            en_val  = (ph < 2) ? CFG_DATA_W'(4'hF) : CFG_DATA_W'($urandom_range(0, 65535));
            act_val = (ph == 0) ? CFG_DATA_W'(N_SLOTS) :
                      (ph == 1) ? CFG_DATA_W'(7) : CFG_DATA_W'($urandom_range(0, 65535));
            put_reg(CFG_ENABLE, en_val);
            put_reg(CFG_ACTIVE, act_val);
            for (int i = 0; i < N_SLOTS; i++) put_reg(CFG_PERIOD0 + CFG_IDX_W'(i), per[i]);
            if ($urandom_range(0, 3) == 0)
                put_reg($urandom_range(0, 1) ? CFG_SPARE1 : CFG_SPARE0,
                        CFG_DATA_W'($urandom_range(0, 65535)));

            step_max = (max_per == '0) ? TICK_W'(8) : TICK_W'(max_per) * LATE_MULT + 2;
            gappy    = (ph < N_PHASES - 2) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0:       tick = $urandom;
                1:       tick = 32'hFFFF_FFFF - TICK_W'($urandom_range(0, 200));
                default: tick = TICK_W'($urandom_range(0, 100));
            endcase
            issue_item(REQ_RESYNC, tick, 1'b1, '0);

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                case ($urandom_range(0, 31))
                    0: begin
                        tick = $urandom;
                        issue_item(REQ_RESYNC, tick, 1'b1, '0);
                    end
                    1: begin
                        tick = $urandom;
                        issue_item(REQ_RUN, tick, 1'b0, '0);
                    end
                    2: begin
                        tick = tick - TICK_W'($urandom_range(1, step_max));
                        issue_item(REQ_RUN, tick, 1'b0, '0);
                    end
                    default: begin
                        tick = tick + TICK_W'($urandom_range(0, step_max));
                        issue_item(REQ_RUN, tick, 1'b0, '0);
                    end
                endcase
                if (gappy && $urandom_range(0, 2) == 0) idle_for($urandom_range(1, 14));
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && fire_mask_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
